### rtl/bdsl_pkg.sv
// Shared types and constants of the button debouncer with short and long press events.
`default_nettype none
package bdsl_pkg;

	localparam int CFG_SLOTS = 4;
	localparam int IDX_W     = 2;
	localparam int SETTLE_W  = 8;
	localparam int LONG_W    = 16;
	localparam int CMP_W     = 32;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DAT_W = 16;
	localparam int S_DATA_W  = 8;
	localparam int M_DATA_W  = 8;

	localparam logic [SETTLE_W-1:0] SETTLE_MAX = '1;

	localparam logic [CFG_IDX_W-1:0] REG_ENABLE_MASK     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_LOW_MASK = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE_TICKS  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_LONG_TICKS_0    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_LONG_TICKS_1    = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_LONG_TICKS_2    = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_LONG_TICKS_3    = 3'd6;

	localparam logic EVENT_SHORT = 1'b0;
	localparam logic EVENT_LONG  = 1'b1;

	localparam logic [SETTLE_W-1:0] DEBOUNCE_RESET = 8'd6;
	localparam logic [LONG_W-1:0]   LONG_RESET     = 16'd200;

	typedef struct packed {
		logic valid;
		logic kind;
	} event_t;

endpackage
`default_nettype wire

### rtl/bdsl_lane.sv
// Per-slot debounce and press timing lane.
`default_nettype none
module bdsl_lane #(
	parameter int HOLD_WIDTH = 16
) (
	input  wire                              clk,
	input  wire                              arst_n,
	input  wire                              tick,
	input  wire                              prime,
	input  wire                              enable,
	input  wire                              invert,
	input  wire                              raw,
	input  wire  [bdsl_pkg::SETTLE_W-1:0]    debounce_ticks,
	input  wire  [bdsl_pkg::LONG_W-1:0]      long_ticks,
	output bdsl_pkg::event_t                 ev
);
	import bdsl_pkg::*;

	localparam logic [HOLD_WIDTH-1:0] HOLD_MAX = '1;

	logic                  prev_q, settled_q, held_q, long_sent_q;
	logic [SETTLE_W-1:0]   settle_cnt_q;
	logic [HOLD_WIDTH-1:0] hold_cnt_q;

	logic                  prev_n, settled_n, held_n, long_sent_n;
	logic [SETTLE_W-1:0]   settle_cnt_n;
	logic [HOLD_WIDTH-1:0] hold_cnt_n;
	logic                  pressed;
	logic                  short_ev, long_ev;

	always_comb begin
		prev_n       = prev_q;
		settled_n    = settled_q;
		held_n       = held_q;
		long_sent_n  = long_sent_q;
		settle_cnt_n = settle_cnt_q;
		hold_cnt_n   = hold_cnt_q;
		short_ev     = 1'b0;
		long_ev      = 1'b0;
		pressed      = raw ^ invert;

		if (held_q && hold_cnt_q != HOLD_MAX) begin
			hold_cnt_n = hold_cnt_q + 1'b1;
		end
		if (raw != prev_q) begin
			prev_n       = raw;
			settle_cnt_n = '0;
		end else if (settle_cnt_q != SETTLE_MAX) begin
			settle_cnt_n = settle_cnt_q + 1'b1;
		end
		if (settle_cnt_n >= debounce_ticks && raw != settled_q) begin
			settled_n = raw;
			if (pressed && !held_q) begin
				held_n      = 1'b1;
				long_sent_n = 1'b0;
				hold_cnt_n  = '0;
			end else if (!pressed && held_q) begin
				held_n   = 1'b0;
				short_ev = !long_sent_q;
			end
		end
		if (held_n && !long_sent_n && CMP_W'(hold_cnt_n) >= CMP_W'(long_ticks)) begin
			long_sent_n = 1'b1;
			long_ev     = 1'b1;
		end

		ev.valid = tick && !prime && enable && (short_ev || long_ev);
		ev.kind  = long_ev ? EVENT_LONG : EVENT_SHORT;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q       <= 1'b0;
			settled_q    <= 1'b0;
			held_q       <= 1'b0;
			long_sent_q  <= 1'b0;
			settle_cnt_q <= '0;
			hold_cnt_q   <= '0;
		end else if (tick && prime) begin
			prev_q       <= raw;
			settled_q    <= raw;
			held_q       <= 1'b0;
			long_sent_q  <= 1'b0;
			settle_cnt_q <= '0;
			hold_cnt_q   <= '0;
		end else if (tick && enable) begin
			prev_q       <= prev_n;
			settled_q    <= settled_n;
			held_q       <= held_n;
			long_sent_q  <= long_sent_n;
			settle_cnt_q <= settle_cnt_n;
			hold_cnt_q   <= hold_cnt_n;
		end
	end

`ifndef ASSERT_OFF
	a_no_event_idle: assert property (@(posedge clk) disable iff (!arst_n)
		ev.valid |-> tick && enable && !prime)
		else $error("event without an enabled tick");
	a_long_once: assert property (@(posedge clk) disable iff (!arst_n)
		(long_sent_q && held_q && tick && enable && !prime && raw == prev_q
			&& raw == settled_q) |-> !ev.valid)
		else $error("long event repeated during one press");
	a_held_hold_zero: assert property (@(posedge clk) disable iff (!arst_n)
		!held_q && $past(!held_q) && $past(tick && enable && !prime)
			|-> hold_cnt_q == $past(hold_cnt_q))
		else $error("hold count moved while released");
`endif

endmodule
`default_nettype wire

### rtl/bdsl_merge.sv
// Event batch register and serializer that merges lane events into the output stream.
`default_nettype none
module bdsl_merge #(
	parameter int LANES = 4
) (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          load,
	input  bdsl_pkg::event_t             ev [LANES],
	output logic                         in_ready,
	output logic                         out_valid,
	input  wire                          out_ready,
	output logic [bdsl_pkg::IDX_W-1:0]   out_index,
	output logic                         out_kind,
	output logic                         out_last
);
	import bdsl_pkg::*;

	logic [LANES-1:0] pend_q, kind_q;
	logic [LANES-1:0] ev_mask, ev_kind, rest;
	logic [IDX_W-1:0] sel;
	logic             advance;
	logic             out_valid_q, out_kind_q, out_last_q;
	logic [IDX_W-1:0] out_index_q;

	always_comb begin
		sel = '0;
		for (int i = LANES - 1; i >= 0; i--) begin
			ev_mask[i] = ev[i].valid;
			ev_kind[i] = ev[i].kind;
			if (pend_q[i]) begin
				sel = IDX_W'(i);
			end
		end
		rest     = pend_q & (pend_q - 1'b1);
		advance  = (|pend_q) && (!out_valid_q || out_ready);
		in_ready = !(|pend_q) || (advance && !(|rest));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else if (load) begin
			pend_q <= ev_mask;
		end else if (advance) begin
			pend_q <= rest;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			kind_q <= ev_kind;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_index_q <= sel;
			out_kind_q  <= kind_q[sel];
			out_last_q  <= !(|rest);
		end
	end

	assign out_valid = out_valid_q;
	assign out_index = out_index_q;
	assign out_kind  = out_kind_q;
	assign out_last  = out_last_q;

`ifndef ASSERT_OFF
	a_load_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		load |-> !(|pend_q) || (advance && !(|rest)))
		else $error("batch loaded over pending events");
	a_batch_taken: assert property (@(posedge clk) disable iff (!arst_n)
		load |=> pend_q == $past(ev_mask))
		else $error("batch register lost a load");
	a_advance_fills: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> out_valid_q)
		else $error("advanced event missing at output");
	a_stall_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> |pend_q)
		else $error("input stalled with empty batch");
`endif

endmodule
`default_nettype wire

### rtl/button_debounce_short_long_press.sv
// Top level of the four-slot button debouncer with short and long press events.
//
// Usage:
// s_* carries one poll tick per transaction: s_tdata[3:0] holds the raw level of
// each button slot. m_* carries the resulting events, one per transaction:
// m_tdata[1:0] is the slot index, m_tuser the kind (0 short release, 1 long press
// reached) and m_tlast marks the final event caused by a tick.
// cfg_* writes one register per transaction: 0 enable mask, 1 active-low mask,
// 2 debounce ticks, 3..6 long press ticks of slots 0..3; other indexes are dropped.
// Path: an accepted tick's events pass the event batch register and then the output register to m_tvalid.
// Throughput: one tick per cycle while ticks cause no events; a tick that causes
// events sends them from the batch register one at a time, and the next tick is taken in the cycle
// the last of them moves into the output register.
// All slots are evaluated in parallel lanes; the event batch register and the
// output register set the rate.
// Reset: configuration returns to its defaults and slot state clears; the first
// tick after reset only captures the levels and emits nothing.
// Stall: while m_tready is low the output register holds its event, and s_tready
// drops once a further tick's events would have no room.
`default_nettype none
module button_debounce_short_long_press #(
	parameter int NUM_SLOTS  = 4,
	parameter int HOLD_WIDTH = 16
) (
	input  wire                                  clk,
	input  wire                                  arst_n,
	input  wire                                  s_tvalid,
	output logic                                 s_tready,
	input  wire  [bdsl_pkg::S_DATA_W-1:0]        s_tdata,   // [3:0] raw_levels
	output logic                                 m_tvalid,
	input  wire                                  m_tready,
	output logic [bdsl_pkg::M_DATA_W-1:0]        m_tdata,   // [1:0] button_index
	output logic                                 m_tuser,   // [0] event_kind
	output logic                                 m_tlast,
	input  wire                                  cfg_valid,
	output logic                                 cfg_ready,
	input  wire  [bdsl_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  wire  [bdsl_pkg::CFG_DAT_W-1:0]       cfg_data
);
	import bdsl_pkg::*;

	localparam int LANES = (NUM_SLOTS < CFG_SLOTS) ? NUM_SLOTS : CFG_SLOTS;

	logic [CFG_SLOTS-1:0] enable_mask_q, low_mask_q;
	logic [SETTLE_W-1:0]  debounce_q;
	logic [LONG_W-1:0]    long_ticks_q [CFG_SLOTS];
	logic                 primed_q;
	logic                 accept;
	logic                 cfg_we;
	logic [IDX_W-1:0]     index;
	event_t               ev [LANES];

	assign cfg_ready = 1'b1;
	assign cfg_we    = cfg_valid && cfg_ready;
	assign accept    = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_mask_q <= '0;
			low_mask_q    <= '0;
			debounce_q    <= DEBOUNCE_RESET;
			for (int i = 0; i < CFG_SLOTS; i++) begin
				long_ticks_q[i] <= LONG_RESET;
			end
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_ENABLE_MASK:     enable_mask_q   <= cfg_data[CFG_SLOTS-1:0];
				REG_ACTIVE_LOW_MASK: low_mask_q      <= cfg_data[CFG_SLOTS-1:0];
				REG_DEBOUNCE_TICKS:  debounce_q      <= cfg_data[SETTLE_W-1:0];
				REG_LONG_TICKS_0:    long_ticks_q[0] <= cfg_data[LONG_W-1:0];
				REG_LONG_TICKS_1:    long_ticks_q[1] <= cfg_data[LONG_W-1:0];
				REG_LONG_TICKS_2:    long_ticks_q[2] <= cfg_data[LONG_W-1:0];
				REG_LONG_TICKS_3:    long_ticks_q[3] <= cfg_data[LONG_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			primed_q <= 1'b0;
		end else if (accept) begin
			primed_q <= 1'b1;
		end
	end

	for (genvar g = 0; g < LANES; g++) begin : g_lane
		bdsl_lane #(
			.HOLD_WIDTH(HOLD_WIDTH)
		) u_lane (
			.clk           (clk),
			.arst_n        (arst_n),
			.tick          (accept),
			.prime         (!primed_q),
			.enable        (enable_mask_q[g]),
			.invert        (low_mask_q[g]),
			.raw           (s_tdata[g]),
			.debounce_ticks(debounce_q),
			.long_ticks    (long_ticks_q[g]),
			.ev            (ev[g])
		);
	end

	bdsl_merge #(
		.LANES(LANES)
	) u_merge (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (accept),
		.ev       (ev),
		.in_ready (s_tready),
		.out_valid(m_tvalid),
		.out_ready(m_tready),
		.out_index(index),
		.out_kind (m_tuser),
		.out_last (m_tlast)
	);

	assign m_tdata = {{(M_DATA_W - IDX_W){1'b0}}, index};

`ifndef ASSERT_OFF
	a_prime_once: assert property (@(posedge clk) disable iff (!arst_n)
		primed_q |=> primed_q)
		else $error("primed flag dropped");
	a_prime_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		accept && !primed_q |=> !m_tvalid || $past(m_tvalid))
		else $error("capture tick produced an event");
	a_data_pad: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[M_DATA_W-1:IDX_W] == '0)
		else $error("event data padding not zero");
`endif

endmodule
`default_nettype wire

### tb/bdsl_event_check.sv
// Watches the tick, event and register channels, predicts press events and compares them.
`default_nettype none
module bdsl_event_check #(
	parameter int HOLD_W = 16
) (
	input  wire                            clk,
	input  wire                            arst_n,
	input  wire                            s_tvalid,
	input  wire                            s_tready,
	input  wire  [bdsl_pkg::S_DATA_W-1:0]  s_tdata,   // [3:0] raw_levels
	input  wire                            m_tvalid,
	input  wire                            m_tready,
	input  wire  [bdsl_pkg::M_DATA_W-1:0]  m_tdata,   // [1:0] button_index
	input  wire                            m_tuser,   // [0] event_kind
	input  wire                            m_tlast,
	input  wire                            cfg_valid,
	input  wire                            cfg_ready,
	input  wire  [bdsl_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire  [bdsl_pkg::CFG_DAT_W-1:0] cfg_data,
	output int                             fail_count,
	output int                             pending,
	output int                             predicted,
	output int                             checked
);
	import bdsl_pkg::*;

	typedef struct packed {
		logic [IDX_W-1:0] slot;
		logic             kind;
		logic             is_last;
	} press_event_t;

	press_event_t press_q[$];

	logic [CFG_SLOTS-1:0] enable_mask;
	logic [CFG_SLOTS-1:0] low_pol;
	logic [SETTLE_W-1:0]  debounce;
	logic [LONG_W-1:0]    long_ticks [CFG_SLOTS];

	logic                 primed;
	logic [CFG_SLOTS-1:0] prev_raw;
	logic [CFG_SLOTS-1:0] settled;
	logic [SETTLE_W-1:0]  settle_cnt [CFG_SLOTS];
	logic [CFG_SLOTS-1:0] held;
	logic [CFG_SLOTS-1:0] long_sent;
	logic [HOLD_W-1:0]    hold_cnt [CFG_SLOTS];

	task automatic report_mismatch(input string msg);
		$display("%0t MISMATCH %s", $realtime, msg);
		fail_count++;
	endtask

	task automatic write_shadow(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] val);
		case (idx)
			REG_ENABLE_MASK:     enable_mask = val[CFG_SLOTS-1:0];
			REG_ACTIVE_LOW_MASK: low_pol = val[CFG_SLOTS-1:0];
			REG_DEBOUNCE_TICKS:  debounce = val[SETTLE_W-1:0];
			REG_LONG_TICKS_0:    long_ticks[0] = val[LONG_W-1:0];
			REG_LONG_TICKS_1:    long_ticks[1] = val[LONG_W-1:0];
			REG_LONG_TICKS_2:    long_ticks[2] = val[LONG_W-1:0];
			REG_LONG_TICKS_3:    long_ticks[3] = val[LONG_W-1:0];
			default: ;
		endcase
	endtask

	task automatic push_press(input int slot, input logic kind);
		press_event_t ev;
		ev.slot = slot[IDX_W-1:0];
		ev.kind = kind;
		ev.is_last = 1'b0;
		press_q.push_back(ev);
		predicted++;
	endtask

	task automatic predict_tick(input logic [CFG_SLOTS-1:0] lv);
		int   n_new;
		logic is_press;
		n_new = 0;
		if (!primed) begin
			for (int i = 0; i < CFG_SLOTS; i++) begin
				prev_raw[i] = lv[i];
				settled[i] = lv[i];
				settle_cnt[i] = '0;
				held[i] = 1'b0;
				long_sent[i] = 1'b0;
				hold_cnt[i] = '0;
			end
			primed = 1'b1;
		end else begin
			for (int i = 0; i < CFG_SLOTS; i++) begin
				if (enable_mask[i]) begin
					if (held[i] && hold_cnt[i] != '1)
						hold_cnt[i]++;
					if (lv[i] != prev_raw[i]) begin
						prev_raw[i] = lv[i];
						settle_cnt[i] = '0;
					end else if (settle_cnt[i] != SETTLE_MAX) begin
						settle_cnt[i]++;
					end
					if (settle_cnt[i] >= debounce && lv[i] != settled[i]) begin
						is_press = lv[i] ^ low_pol[i];
						settled[i] = lv[i];
						if (is_press && !held[i]) begin
							held[i] = 1'b1;
							long_sent[i] = 1'b0;
							hold_cnt[i] = '0;
						end else if (!is_press && held[i]) begin
							held[i] = 1'b0;
							if (!long_sent[i]) begin
								push_press(i, EVENT_SHORT);
								n_new++;
							end
						end
					end
					if (held[i] && !long_sent[i] && hold_cnt[i] >= long_ticks[i]) begin
						long_sent[i] = 1'b1;
						push_press(i, EVENT_LONG);
						n_new++;
					end
				end
			end
			if (n_new > 0)
				press_q[press_q.size()-1].is_last = 1'b1;
		end
	endtask

	task automatic compare_event();
		press_event_t want;
		if (press_q.size() == 0) begin
			report_mismatch($sformatf("event with none pending: tdata %0h kind %0b last %0b",
				m_tdata, m_tuser, m_tlast));
		end else begin
			want = press_q.pop_front();
			checked++;
			if (m_tdata !== {{(M_DATA_W-IDX_W){1'b0}}, want.slot})
				report_mismatch($sformatf("slot: got tdata %0h, want %0d", m_tdata, want.slot));
			if (m_tuser !== want.kind)
				report_mismatch($sformatf("kind of slot %0d: got %0b, want %0b",
					want.slot, m_tuser, want.kind));
			if (m_tlast !== want.is_last)
				report_mismatch($sformatf("last of slot %0d: got %0b, want %0b",
					want.slot, m_tlast, want.is_last));
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_mask = '0;
			low_pol = '0;
			debounce = DEBOUNCE_RESET;
			primed = 1'b0;
			prev_raw = '0;
			settled = '0;
			held = '0;
			long_sent = '0;
			for (int i = 0; i < CFG_SLOTS; i++) begin
				long_ticks[i] = LONG_RESET;
				settle_cnt[i] = '0;
				hold_cnt[i] = '0;
			end
			press_q.delete();
			fail_count = 0;
			predicted = 0;
			checked = 0;
			pending <= 0;
		end else begin
			if (cfg_valid && cfg_ready)
				write_shadow(cfg_index, cfg_data);
			if (s_tvalid && s_tready)
				predict_tick(s_tdata[CFG_SLOTS-1:0]);
			if (m_tvalid && m_tready)
				compare_event();
			pending <= press_q.size();
		end
	end

endmodule
`default_nettype wire

### tb/tb_top.sv
// Top of the button debouncer testbench: clock, reset, tick and register stimulus, verdict.
`default_nettype none
module tb_top;
	import bdsl_pkg::*;

	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;
	localparam int TICK_TARGET = 470;
	localparam int STALL_LIMIT = 2000;
	localparam int DRAIN_CYCLES = 4;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 s_tvalid = 1'b0;
	logic [S_DATA_W-1:0]  s_tdata = '0;
	wire                  s_tready;
	wire                  m_tvalid;
	logic                 m_tready = 1'b0;
	wire  [M_DATA_W-1:0]  m_tdata;
	wire                  m_tuser;
	wire                  m_tlast;
	logic                 cfg_valid = 1'b0;
	wire                  cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DAT_W-1:0] cfg_data = '0;

	int fail_count;
	int pending;
	int predicted;
	int checked;

	bit         calm = 1'b0;
	int         ticks_sent = 0;
	int         cfg_writes = 0;
	int         settings = 0;
	int         quiet_cycles = 0;
	int         phase;
	logic [3:0] last_lv = '0;

	button_debounce_short_long_press u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	bdsl_event_check u_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tuser    (m_tuser),
		.m_tlast    (m_tlast),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.fail_count (fail_count),
		.pending    (pending),
		.predicted  (predicted),
		.checked    (checked)
	);

	always #4 clk = ~clk;

	always @(posedge clk) begin
		m_tready <= calm || ($urandom_range(99) >= 9);
	end

	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
				(cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("stalled for %0d cycles with %0d events pending", quiet_cycles, pending);
				$display("tb_top failed");
				$finish;
			end
		end
	end

	task automatic send_tick(input logic [3:0] lv);
		while (!calm && $urandom_range(99) < 9) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {{(S_DATA_W-4){1'b0}}, lv};
		do @(posedge clk); while (!s_tready);
		last_lv = lv;
		ticks_sent++;
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] val);
		while (!calm && $urandom_range(99) < 9) begin
			cfg_valid <= 1'b0;
			@(posedge clk);
		end
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_writes++;
	endtask

	task automatic apply_config(input logic [3:0] en, input logic [3:0] al, input logic [7:0] deb,
			input logic [15:0] l0, input logic [15:0] l1, input logic [15:0] l2,
			input logic [15:0] l3);
		write_reg(REG_ENABLE_MASK, {12'd0, en});
		write_reg(REG_ACTIVE_LOW_MASK, {12'd0, al});
		write_reg(REG_DEBOUNCE_TICKS, {8'd0, deb});
		write_reg(REG_LONG_TICKS_0, l0);
		write_reg(REG_LONG_TICKS_1, l1);
		write_reg(REG_LONG_TICKS_2, l2);
		write_reg(REG_LONG_TICKS_3, l3);
		if ($urandom_range(3) == 0)
			write_reg(REG_UNUSED, 16'($urandom()));
		cfg_valid <= 1'b0;
		settings++;
	endtask

	// wait for every predicted event, then let the pipeline empty
	task automatic drain();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (pending != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	function automatic logic [15:0] pick_long();
		int r;
		r = $urandom_range(99);
		if (r < 80)
			return 16'($urandom_range(12));
		else if (r < 90)
			return 16'hFFFF;
		return 16'($urandom());
	endfunction

	// bounce, then hold one level long enough to settle
	task automatic press_gesture(input int deb);
		logic [3:0] target;
		target = 4'($urandom_range(15));
		repeat ($urandom_range(3)) send_tick(4'($urandom_range(15)));
		repeat (deb + $urandom_range(1, 16)) send_tick(target);
	endtask

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// zero debounce, zero and small long ticks, and a long count out of reach
		apply_config(4'hF, 4'h0, 8'd0, 16'd0, 16'd2, 16'hFFFF, 16'd1);
		send_tick(4'b0000);
		send_tick(4'b1111);
		send_tick(4'b1111);
		send_tick(4'b1111);
		send_tick(4'b0000);
		send_tick(4'b1111);
		send_tick(4'b0000);
		drain();

		// flip polarity under settled levels: release while not held, then four longs at once
		apply_config(4'hF, 4'hF, 8'd2, 16'd0, 16'd0, 16'd0, 16'd0);
		repeat (3) send_tick(4'b1111);
		repeat (3) send_tick(4'b0000);
		drain();

		// flip back while held: press while already held, release after long
		apply_config(4'hF, 4'h0, 8'd2, 16'd0, 16'd0, 16'd0, 16'd0);
		repeat (3) send_tick(4'b1111);
		repeat (3) send_tick(4'b0000);
		drain();

		// freeze slots one and three, then resume them
		apply_config(4'b0101, 4'h0, 8'd1, 16'd3, 16'd3, 16'd3, 16'd3);
		repeat (2) send_tick(4'b1111);
		repeat (2) send_tick(4'b0000);
		drain();
		apply_config(4'hF, 4'h0, 8'd0, 16'd3, 16'd3, 16'd3, 16'd3);
		send_tick(4'b1010);
		send_tick(4'b0000);
		drain();

		phase = 0;
		while (ticks_sent < TICK_TARGET) begin
			calm = (phase == 1);
			if (phase == 2) begin
				logic [3:0] hold_lv;
				// longest debounce: settle count has to saturate
				hold_lv = ~last_lv;
				apply_config(4'hF, 4'($urandom_range(15)), SETTLE_MAX, 16'd0, 16'hFFFF,
					16'($urandom()), 16'd0);
				repeat (258) send_tick(hold_lv);
			end else begin
				logic [3:0] en;
				logic [7:0] deb;
				en = ($urandom_range(9) < 7) ? 4'hF : 4'($urandom_range(15));
				deb = ($urandom_range(99) < 80) ? 8'($urandom_range(4)) : 8'($urandom_range(5, 10));
				apply_config(en, 4'($urandom_range(15)), deb, pick_long(), pick_long(),
					pick_long(), pick_long());
				repeat ($urandom_range(4, 10)) begin
					if ($urandom_range(99) < 85)
						press_gesture(int'(deb));
					else
						repeat ($urandom_range(1, 6)) send_tick(4'($urandom_range(15)));
				end
			end
			drain();
			phase++;
		end
		calm = 1'b0;

		repeat (8) @(posedge clk);
		$display("covered %0d ticks over %0d settings (%0d register writes)",
			ticks_sent, settings, cfg_writes);
		$display("compared %0d press events, %0d left pending", checked, pending);
		if (fail_count == 0 && pending == 0)
			$display("tb_top passed");
		else
			$display("tb_top failed");
		$finish;
	end

endmodule
`default_nettype wire
